// ===== hw/rtl/smdm_pkg.sv =====
// Shared package for the sparse-dense matrix multiply block.
// Holds command codes, field widths, defaults and inter-module structs; depends on nothing.
`default_nettype none

package smdm_pkg;

   // field widths (fixed by the interface)
   localparam int CMD_W    = 2;
   localparam int BROW_W   = 10;
   localparam int BCOL_W   = 6;
   localparam int ACOL_W   = 10;
   localparam int VALUE_W  = 32;
   localparam int ROW_W    = 16;
   localparam int COL_W    = 6;
   localparam int NCOLS_W  = 7;
   localparam int ACC_W    = 64;

   // parameter defaults
   localparam int B_ROWS_DEF   = 1024;
   localparam int MAX_COLS_DEF = 64;

   localparam logic [NCOLS_W-1:0] NUM_COLS_RESET = 7'd64;

   // request commands
   localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd0;
   localparam logic [CMD_W-1:0] CMD_NONZERO = 2'd1;
   localparam logic [CMD_W-1:0] CMD_END_ROW = 2'd2;

   // one accumulator update entering the MAC pipe
   typedef struct packed {
      logic             vld;
      logic             hit;   // accumulator entry holds data since last clear
      logic [COL_W-1:0] col;
   } mac_ctl_type;

   // write-back from the MAC pipe
   typedef struct packed {
      logic             we;
      logic [COL_W-1:0] col;
      logic [ACC_W-1:0] data;
   } acc_wr_type;

   // one result moving into the output register
   typedef struct packed {
      logic             load;
      logic             hit;
      logic             last;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
   } emit_ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/csr_sparse_dense_matmul.sv =====
// Top level of the CSR sparse by dense matrix multiply (Q16.16, saturating).
// Depends on smdm_pkg, smdm_ram, smdm_mac and smdm_emit.
`default_nettype none

// Multiplies a sparse matrix A, streamed row by row as CSR nonzeros, by a dense matrix B
// held in an on-chip RAM of B_ROWS x MAX_COLS 32-bit words. A request with cmd 0 writes one
// B entry (out-of-range rows/columns are dropped); cmd 1 adds value * B[a_col][j] into the
// row accumulators j = 0 .. n-1 (a_col out of range is dropped); cmd 2 emits n results for
// the current row, clears the accumulators and bumps the 16-bit row number; cmd 3 is a no-op.
// n is num_out_cols, with 0 read as 1 and values above MAX_COLS read as MAX_COLS. B entries
// that were never written read as garbage. Accumulators are 64-bit saturating and live in a
// MAX_COLS-entry RAM with one valid flop per entry, so a clear resets every valid flop at
// once and no clearing pass is needed after reset. cmd 0 and cmd 3 never stall the next
// request; cmd 1 stalls it while the accumulators are read, one column per cycle, over the
// single read port of the accumulator RAM, then pass the read, multiply and add stages; cmd 2
// stalls it while results are read over that port, one result per cycle unless rsp_stall
// holds them. The output register lets the next request in while the last result waits.
// The num_out_cols register is written through csr_valid/csr_ready, only accepted while idle.
module csr_sparse_dense_matmul #(
   parameter int B_ROWS   = smdm_pkg::B_ROWS_DEF,
   parameter int MAX_COLS = smdm_pkg::MAX_COLS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic        [smdm_pkg::CMD_W-1:0]   req_cmd,
   input  wire logic        [smdm_pkg::BROW_W-1:0]  req_b_row,
   input  wire logic        [smdm_pkg::BCOL_W-1:0]  req_b_col,
   input  wire logic        [smdm_pkg::ACOL_W-1:0]  req_a_col,
   input  wire logic signed [smdm_pkg::VALUE_W-1:0] req_value,
   // response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic             [smdm_pkg::ROW_W-1:0]   rsp_row_index,
   output logic             [smdm_pkg::COL_W-1:0]   rsp_out_col,
   output logic signed      [smdm_pkg::VALUE_W-1:0] rsp_out_value,
   output logic                                     rsp_last_of_row,
   // num_out_cols register write
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic        [smdm_pkg::NCOLS_W-1:0] csr_wdata
);
   import smdm_pkg::*;

   localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;   // column address bits
   localparam int RA_W   = (B_ROWS > 1) ? $clog2(B_ROWS) : 1;       // B row address bits
   localparam int BA_W   = RA_W + CW;
   localparam int B_DEPTH = B_ROWS * (2 ** CW);

   // sequencer states
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_MAC   = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;
   localparam logic [1:0] S_EMIT  = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [CW-1:0]         col_ff, col_in;
   logic [CW-1:0]         last_ff, last_in;
   logic                  done_ff, done_in;        // all emit reads issued
   logic [RA_W-1:0]       a_col_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic [NCOLS_W-1:0]    ncols_ff;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [MAX_COLS-1:0]   vld_ff, vld_in;          // accumulator entry written since clear

   // read-stage tracking (data of the last issued read sits in the RAM output)
   logic                  rd_vld_ff;               // MAC read in flight
   logic                  rd_pend_ff, rd_pend_in;  // emit read waiting for the output reg
   logic [CW-1:0]         rd_col_ff;
   logic                  rd_last_ff;
   logic                  rd_hit_ff;

   logic                  accept;
   logic                  issue_mac, issue_emit, acc_re, load;
   logic [NCOLS_W-1:0]    last_idx;
   logic [VALUE_W-1:0]    b_rdata;
   logic [ACC_W-1:0]      acc_rdata;
   logic                  b_we;

   mac_ctl_type           mac_ctl;
   acc_wr_type            acc_wr;
   emit_ctl_type          emit_ctl;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);

   // highest column index in use
   always_comb begin
      if (ncols_ff == '0) begin
         last_idx = '0;
      end else if (32'(ncols_ff) > MAX_COLS) begin
         last_idx = NCOLS_W'(MAX_COLS - 1);
      end else begin
         last_idx = ncols_ff - 7'd1;
      end
   end

   assign b_we = accept && (req_cmd == CMD_WRITE_B) && (32'(req_b_row) < B_ROWS)
                 && (32'(req_b_col) < MAX_COLS);

   assign issue_mac  = (state_ff == S_MAC);
   assign load       = rd_pend_ff && (!rsp_valid || !rsp_stall);
   assign issue_emit = (state_ff == S_EMIT) && !done_ff && (!rd_pend_ff || load);
   assign acc_re     = issue_mac || issue_emit;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      col_in     = col_ff;
      last_in    = last_ff;
      done_in    = done_ff;
      row_in     = row_ff;
      vld_in     = vld_ff;
      rd_pend_in = issue_emit || (rd_pend_ff && !load);

      if (acc_wr.we) begin
         vld_in[CW'(acc_wr.col)] = 1'b1;
      end

      case (state_ff)
         S_IDLE: begin
            col_in  = '0;
            done_in = 1'b0;
            last_in = CW'(last_idx);
            if (accept && (req_cmd == CMD_NONZERO) && (32'(req_a_col) < B_ROWS)) begin
               state_in = S_MAC;
            end else if (accept && (req_cmd == CMD_END_ROW)) begin
               state_in = S_EMIT;
            end
         end
         S_MAC: begin
            col_in = col_ff + CW'(1);
            if (col_ff == last_ff) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!rd_vld_ff && !acc_wr.we) begin
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (issue_emit) begin
               col_in = col_ff + CW'(1);
               if (col_ff == last_ff) begin
                  done_in = 1'b1;
               end
            end
            if (load && rd_last_ff) begin
               state_in = S_IDLE;
               vld_in   = '0;
               row_in   = row_ff + ROW_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         col_ff     <= '0;
         last_ff    <= '0;
         done_ff    <= 1'b0;
         row_ff     <= '0;
         vld_ff     <= '0;
         rd_vld_ff  <= 1'b0;
         rd_pend_ff <= 1'b0;
         ncols_ff   <= NUM_COLS_RESET;
      end else begin
         state_ff   <= state_in;
         col_ff     <= col_in;
         last_ff    <= last_in;
         done_ff    <= done_in;
         row_ff     <= row_in;
         vld_ff     <= vld_in;
         rd_vld_ff  <= issue_mac;
         rd_pend_ff <= rd_pend_in;
         if (csr_valid && csr_ready) begin
            ncols_ff <= csr_wdata;
         end
      end
      if (accept) begin
         a_col_ff <= RA_W'(req_a_col);
         value_ff <= req_value;
      end
      if (acc_re) begin
         rd_col_ff  <= col_ff;
         rd_last_ff <= (col_ff == last_ff);
         rd_hit_ff  <= vld_ff[col_ff];
      end
   end

   smdm_ram #(
      .WIDTH  (VALUE_W),
      .DEPTH  (B_DEPTH),
      .ADDR_W (BA_W)
   ) u_b_ram (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr ({RA_W'(req_b_row), CW'(req_b_col)}),
      .wr_data (req_value),
      .rd_en   (issue_mac),
      .rd_addr ({a_col_ff, col_ff}),
      .rd_data (b_rdata)
   );

   smdm_ram #(
      .WIDTH  (ACC_W),
      .DEPTH  (MAX_COLS),
      .ADDR_W (CW)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (acc_wr.we),
      .wr_addr (CW'(acc_wr.col)),
      .wr_data (acc_wr.data),
      .rd_en   (acc_re),
      .rd_addr (col_ff),
      .rd_data (acc_rdata)
   );

   always_comb begin
      mac_ctl.vld = rd_vld_ff;
      mac_ctl.hit = rd_hit_ff;
      mac_ctl.col = COL_W'(rd_col_ff);

      emit_ctl.load = load;
      emit_ctl.hit  = rd_hit_ff;
      emit_ctl.last = rd_last_ff;
      emit_ctl.col  = COL_W'(rd_col_ff);
      emit_ctl.row  = row_ff;
   end

   smdm_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctl      (mac_ctl),
      .a_value  (value_ff),
      .b_data   (b_rdata),
      .acc_data (acc_rdata),
      .wr       (acc_wr)
   );

   smdm_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .ctl             (emit_ctl),
      .acc_data        (acc_rdata),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_row_index   (rsp_row_index),
      .rsp_out_col     (rsp_out_col),
      .rsp_out_value   (rsp_out_value),
      .rsp_last_of_row (rsp_last_of_row)
   );

`ifndef SYNTH
   // accumulator write-back only while a nonzero is in progress
   assert property (@(posedge clock) disable iff (reset)
      acc_wr.we |-> (state_ff == S_MAC || state_ff == S_DRAIN))
      else $error("accumulator write outside nonzero update");

   // a result never overwrites one still waiting downstream
   assert property (@(posedge clock) disable iff (reset)
      load |-> (!rsp_valid || !rsp_stall))
      else $error("output register overrun");

   // emit reads only pend inside an end-of-row sequence
   assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> (state_ff == S_EMIT))
      else $error("pending accumulator read outside emit");

   // end of row starts the emit sequence
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == CMD_END_ROW) |=> (state_ff == S_EMIT))
      else $error("end of row did not start emit");

   // last result of a row clears every accumulator and returns to idle
   assert property (@(posedge clock) disable iff (reset)
      (load && rd_last_ff) |=> (state_ff == S_IDLE && vld_ff == '0))
      else $error("row end did not clear accumulators");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/smdm_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module smdm_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/smdm_mac.sv =====
// Multiply-accumulate pipe: registered 32x32 product, then 64-bit saturating add.
// Depends on smdm_pkg.
`default_nettype none

module smdm_mac (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire smdm_pkg::mac_ctl_type               ctl,
   input  wire logic signed [smdm_pkg::VALUE_W-1:0] a_value,
   input  wire logic        [smdm_pkg::VALUE_W-1:0] b_data,
   input  wire logic        [smdm_pkg::ACC_W-1:0]   acc_data,
   output smdm_pkg::acc_wr_type                     wr
);
   import smdm_pkg::*;

   logic signed [ACC_W-1:0] prod_ff;
   logic        [ACC_W-1:0] accv_ff;
   logic                    vld_ff;
   logic        [COL_W-1:0] col_ff;
   logic        [ACC_W-1:0] sum;
   logic                    ovf;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= ctl.vld;
      end
      prod_ff <= a_value * $signed(b_data);
      accv_ff <= ctl.hit ? acc_data : '0;
      col_ff  <= ctl.col;
   end

   always_comb begin
      sum = accv_ff + prod_ff;
      ovf = (accv_ff[ACC_W-1] == prod_ff[ACC_W-1]) && (sum[ACC_W-1] != accv_ff[ACC_W-1]);
      wr.we  = vld_ff;
      wr.col = col_ff;
      if (!ovf) begin
         wr.data = sum;
      end else if (accv_ff[ACC_W-1]) begin
         wr.data = {1'b1, {(ACC_W-1){1'b0}}};
      end else begin
         wr.data = {1'b0, {(ACC_W-1){1'b1}}};
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/smdm_emit.sv =====
// Result stage: Q32.32 accumulator to saturated Q16.16 and the response output register.
// Depends on smdm_pkg.
`default_nettype none

module smdm_emit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire smdm_pkg::emit_ctl_type              ctl,
   input  wire logic        [smdm_pkg::ACC_W-1:0]   acc_data,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_valid,
   output logic             [smdm_pkg::ROW_W-1:0]   rsp_row_index,
   output logic             [smdm_pkg::COL_W-1:0]   rsp_out_col,
   output logic signed      [smdm_pkg::VALUE_W-1:0] rsp_out_value,
   output logic                                     rsp_last_of_row
);
   import smdm_pkg::*;

   logic               full_ff;
   logic               full_in;
   logic [ACC_W-1:0]   acc;
   logic [VALUE_W-1:0] q16;

   // floor shift by 16, then clamp to 32 bits
   always_comb begin
      acc = ctl.hit ? acc_data : '0;
      if ((&acc[ACC_W-1:47]) || !(|acc[ACC_W-1:47])) begin
         q16 = acc[47:16];
      end else if (acc[ACC_W-1]) begin
         q16 = {1'b1, {(VALUE_W-1){1'b0}}};
      end else begin
         q16 = {1'b0, {(VALUE_W-1){1'b1}}};
      end
      full_in = ctl.load || (full_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
      if (ctl.load) begin
         rsp_row_index   <= ctl.row;
         rsp_out_col     <= ctl.col;
         rsp_out_value   <= $signed(q16);
         rsp_last_of_row <= ctl.last;
      end
   end

   assign rsp_valid = full_ff;

endmodule

`default_nettype wire
